@@ src/ssq_pkg.sv @@
// Shared types, sizes and codes for the stable sorted priority queue.
// No dependencies; every other file in src imports this package.
package ssq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DUP   = 2'd3;

   typedef struct packed {
      logic               action;
      logic [15:0]        item_id;
      logic [7:0]         kind;
      logic signed [15:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        out_item_id;
      logic [7:0]         out_kind;
      logic signed [15:0] out_priority;
      logic [4:0]         count;
   } rsp_type;

   // one stored entry without its valid bit
   typedef struct packed {
      logic [15:0]        handle;
      logic [7:0]         kind;
      logic signed [15:0] prio;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } ctl_type;

   // resize the entry count to the 5-bit count field
   function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[4:0];
   endfunction

endpackage

@@ src/ssq_cell.sv @@
// One slot of the sorted chain: holds an entry, compares it with the new word
// and takes the new word or its left neighbor on insert, its right neighbor on remove. Depends on ssq_pkg.
module ssq_cell (
   input  logic               clock,
   input  logic               reset,
   input  ssq_pkg::ctl_type   ctl,
   input  ssq_pkg::entry_type new_entry,
   input  logic               left_valid,
   input  logic               left_greater,
   input  ssq_pkg::entry_type left_entry,
   input  logic               right_valid,
   input  ssq_pkg::entry_type right_entry,
   output logic               valid,
   output logic               greater,
   output logic               dup,
   output ssq_pkg::entry_type entry
);
   import ssq_pkg::*;

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;
   logic      take_new;

   // compare against the word being inserted
   assign greater  = valid_ff && (data_ff.prio > new_entry.prio);
   assign dup      = valid_ff && (data_ff.handle == new_entry.handle);
   assign take_new = !left_greater && (greater || (!valid_ff && left_valid));

   // shift right on insert, shift left on remove, else hold
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.rem) begin
         valid_in = right_valid;
         data_in  = right_entry;
      end else if (ctl.ins) begin
         if (left_greater) begin
            valid_in = 1'b1;
            data_in  = left_entry;
         end else if (take_new) begin
            valid_in = 1'b1;
            data_in  = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign entry = data_ff;

endmodule

@@ src/stable_sorted_priority_queue.sv @@
// Stable sorted priority queue: a chain of CAPACITY cells kept sorted by
// ascending signed priority, FIFO among equal priorities. Busy never rises:
// a word is taken at each edge with start high, and its result appears on
// rsp with rsp_strobe in the next cycle. The receiver cannot stall: rsp
// holds a result for the single strobe cycle only and must be captured at
// the edge that ends it. The duplicate-handle check compares all cells in
// parallel in the cycle that the word is taken.
// Depends on ssq_pkg and ssq_cell.
module stable_sorted_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ssq_pkg::req_type req,
   output logic             rsp_strobe,
   output ssq_pkg::rsp_type rsp
);
   import ssq_pkg::*;

   logic [CAPACITY-1:0] valid_vec, greater_vec, dup_vec;
   entry_type           entry_vec [CAPACITY];
   entry_type           new_entry;
   ctl_type             ctl;
   logic                accept, full, empty, any_dup;
   logic [CNT_W-1:0]    count_ff, count_in;
   rsp_type             rsp_ff, rsp_in;
   logic                strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign new_entry.handle = req.item_id;
   assign new_entry.kind   = req.kind;
   assign new_entry.prio   = req.priority_req;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign any_dup = |dup_vec;

   assign ctl.ins = accept && (req.action == ACT_INSERT) && !full && !any_dup;
   assign ctl.rem = accept && (req.action == ACT_REMOVE) && !empty;

   // build the chain
   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic      lv, lg, rv;
         entry_type le, re;
         if (i == 0) begin : g_head
            assign lv = 1'b1;
            assign lg = 1'b0;
            assign le = new_entry;
         end else begin : g_mid
            assign lv = valid_vec[i-1];
            assign lg = greater_vec[i-1];
            assign le = entry_vec[i-1];
         end
         if (i == CAPACITY - 1) begin : g_tail
            assign rv = 1'b0;
            assign re = new_entry;
         end else begin : g_body
            assign rv = valid_vec[i+1];
            assign re = entry_vec[i+1];
         end
         ssq_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .new_entry    (new_entry),
            .left_valid   (lv),
            .left_greater (lg),
            .left_entry   (le),
            .right_valid  (rv),
            .right_entry  (re),
            .valid        (valid_vec[i]),
            .greater      (greater_vec[i]),
            .dup          (dup_vec[i]),
            .entry        (entry_vec[i])
         );
      end
   endgenerate

   // advance the entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // form the result word
   always_comb begin
      rsp_in        = '0;
      rsp_in.count  = count_field(count_in);
      if (req.action == ACT_REMOVE) begin
         if (empty) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.status       = ST_OK;
            rsp_in.out_item_id  = entry_vec[0].handle;
            rsp_in.out_kind     = entry_vec[0].kind;
            rsp_in.out_priority = entry_vec[0].prio;
         end
      end else if (full) begin
         rsp_in.status = ST_FULL;
      end else if (any_dup) begin
         rsp_in.status = ST_DUP;
      end else begin
         rsp_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // count always equals the number of occupied cells
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count differs from occupied cells");

   // an empty head means an empty chain (the prefix property, checked at the head only)
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      !valid_vec[0] |-> (valid_vec == '0))
      else $error("chain has a hole at the head");

   // every accepted word yields one result next cycle
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing result strobe");

   // head is served first: removal never returns a priority above the next cell
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (valid_vec[0] && valid_vec[1]) |-> (entry_vec[0].prio <= entry_vec[1].prio))
      else $error("head out of order");

endmodule

@@ dv/ssq_check_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the stable sorted priority queue: a predictor of the queue
// contents and the list of responses still owed. Depends on ssq_pkg.
package ssq_check_pkg;

   import ssq_pkg::*;

   class queue_scoreboard;

      // predicted queue contents, sorted, occupied from slot 0
      entry_type slots[CAPACITY];
      int        held;
      // responses owed by the block, oldest first
      rsp_type   owed_rsp[$];
      int        errors;
      int        rsp_seen;

      function new();
         held     = 0;
         errors   = 0;
         rsp_seen = 0;
      endfunction

      function int owed_count();
         return owed_rsp.size();
      endfunction

      task report(input string msg);
         $display("%0t ns MISMATCH: %s", $time, msg);
         errors++;
      endtask

      // Predict the response to one accepted word and update the queue.
      function void note_request(input req_type w);
         rsp_type r;
         int      i;
         int      pos;
         bit      dup;
         r = '0;
         if (w.action == ACT_INSERT) begin
            // full takes precedence over duplicate
            if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               dup = 1'b0;
               for (i = 0; i < held; i++) begin
                  if (slots[i].handle == w.item_id) dup = 1'b1;
               end
               if (dup) begin
                  r.status = ST_DUP;
               end else begin
                  // walk past every entry with priority not above the new one
                  pos = 0;
                  while (pos < held && slots[pos].prio <= w.priority_req) pos++;
                  for (i = held; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos].handle = w.item_id;
                  slots[pos].kind   = w.kind;
                  slots[pos].prio   = w.priority_req;
                  held++;
                  r.status = ST_OK;
               end
            end
         end else begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // pop the head and close the gap
               r.status       = ST_OK;
               r.out_item_id  = slots[0].handle;
               r.out_kind     = slots[0].kind;
               r.out_priority = slots[0].prio;
               for (i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
               held--;
            end
         end
         r.count = 5'(held);
         owed_rsp.push_back(r);
      endfunction

      task check_field(input string name, input logic signed [31:0] got,
                       input logic signed [31:0] want);
         if (got !== want)
            report($sformatf("response %0d %s got %0d want %0d", rsp_seen, name, got, want));
      endtask

      // Compare one response word against the oldest prediction.
      task check_response(input rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            report($sformatf("response %0d arrived with none owed", rsp_seen));
         end else begin
            want = owed_rsp.pop_front();
            check_field("status", got.status, want.status);
            check_field("out_item_id", got.out_item_id, want.out_item_id);
            check_field("out_kind", got.out_kind, want.out_kind);
            check_field("out_priority", got.out_priority, want.out_priority);
            check_field("count", got.count, want.count);
         end
         rsp_seen++;
      endtask

   endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Top-level testbench of the stable sorted priority queue: directed and
// random insert/remove words. Depends on ssq_pkg, ssq_check_pkg and the RTL.
module tb;

   import ssq_pkg::*;
   import ssq_check_pkg::*;

   localparam int RANDOM_WORDS = 850;
   localparam int QUIET_TAIL   = 80;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req   = '0;
   logic    rsp_strobe;
   rsp_type rsp;

   int cycles = 0;

   queue_scoreboard sb = new();

   stable_sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Check responses and note accepted words at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_response(rsp);
         if (start && !busy) sb.note_request(req);
      end
   end

   // Present one word and hold it until the block takes it.
   task automatic send_word(input req_type w);
      bit taken;
      start <= 1'b1;
      req   <= w;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic req_type insert_word(input logic [15:0] h, input logic [7:0] k,
                                           input logic signed [15:0] p);
      req_type w;
      w.action       = ACT_INSERT;
      w.item_id      = h;
      w.kind         = k;
      w.priority_req = p;
      return w;
   endfunction

   function automatic req_type remove_word();
      req_type w;
      w        = '0;
      w.action = ACT_REMOVE;
      return w;
   endfunction

   // Random word: handles from a small pool to hit duplicates, priorities
   // clustered near zero to hit ties; unused fields on remove stay random.
   function automatic req_type random_word(input int insert_pct);
      req_type w;
      int      pick;
      w.action = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      pick = $urandom_range(9);
      if (pick < 6)      w.item_id = 16'($urandom_range(23));
      else if (pick < 7) w.item_id = 16'hFFFF - 16'($urandom_range(3));
      else               w.item_id = 16'($urandom);
      w.kind = 8'($urandom);
      pick = $urandom_range(9);
      if (pick < 5)      w.priority_req = 16'(int'($urandom_range(6)) - 3);
      else if (pick < 6) w.priority_req = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else               w.priority_req = 16'($urandom);
      return w;
   endfunction

   initial begin
      int i;
      int n;
      int blk;
      int pct;
      bit gappy;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty remove, field extremes, duplicates on both sides of
      // the insertion point, equal-priority order, full and full-with-duplicate.
      send_word(remove_word());
      send_word(insert_word(16'h0000, 8'h00, 16'sh8000));
      send_word(insert_word(16'hFFFF, 8'hFF, 16'sh7FFF));
      send_word(insert_word(16'h0000, 8'h5A, 16'sh7FFF));
      send_word(insert_word(16'hFFFF, 8'hA5, 16'sh8000));
      for (i = 1; i <= 3; i++) send_word(insert_word(16'(i), 8'(i * 16), 16'sd5));
      for (i = 0; i < 11; i++)
         send_word(insert_word(16'h0100 + 16'(i), 8'(8'hC0 + i), 16'((i % 3) - 1)));
      send_word(insert_word(16'h0200, 8'h33, 16'sd0));
      send_word(insert_word(16'h0000, 8'h33, 16'sd0));
      for (i = 0; i < 3; i++) send_word(remove_word());

      // Random: blocks that lean toward filling, draining or neither,
      // some with idle bursts; the tail runs back to back.
      n = 0;
      while (n < RANDOM_WORDS) begin
         blk = $urandom_range(60, 20);
         case ($urandom_range(2))
            0:       pct = 85;
            1:       pct = 15;
            default: pct = 50;
         endcase
         gappy = $urandom_range(1);
         for (i = 0; i < blk && n < RANDOM_WORDS; i++) begin
            if (gappy && n < RANDOM_WORDS - QUIET_TAIL && $urandom_range(3) == 0)
               idle_cycles($urandom_range(19, 1));
            send_word(random_word(pct));
            n++;
         end
      end

      // Drain and let any stray response show up.
      start <= 1'b0;
      while (sb.owed_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ stable_sorted_priority_queue.f @@
src/ssq_pkg.sv
src/ssq_cell.sv
src/stable_sorted_priority_queue.sv
dv/ssq_check_pkg.sv
dv/tb.sv
